### rtl/assert_macros.svh
// Assertion macros shared by the console writer RTL.
// Depends on nothing; the including module must have clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property at every clock edge outside reset.
`define TCW_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");
// Check that a condition implies another in the next cycle.
`define TCW_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define TCW_ASSERT(name, prop)
`define TCW_ASSERT_NEXT(name, ante, cons)
`endif

`endif

### rtl/tcw_pkg.sv
// Shared types, constants and the control store of the console writer.
// Depends on nothing; used by the sequencer, the datapath and the top level.
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry and field widths
  localparam int COLS       = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = COLS * ROWS;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 5;
  localparam int ADDR_W     = 11;
  localparam int QUO_W      = 7;
  localparam int RECIP_SH   = 16;
  localparam int DIV_RECIP  = (1 << RECIP_SH) / COLS;
  localparam int LAST_COPY  = (ROWS - 1) * COLS - 1;

  localparam logic [7:0] BLANK_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] RETURN_CHAR  = 8'h0D;
  localparam logic [7:0] ATTR_RESET   = 8'h05;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_SETPOS = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  // Datapath actions driven by one control word
  typedef enum logic [3:0] {
    ACT_NOP     = 4'd0,
    ACT_PUT     = 4'd1,
    ACT_DIV     = 4'd2,
    ACT_SETPOS  = 4'd3,
    ACT_READ    = 4'd4,
    ACT_CNT_CLR = 4'd5,
    ACT_SCR_RD  = 4'd6,
    ACT_SCR_MV  = 4'd7,
    ACT_FILL    = 4'd8
  } act_t;

  typedef enum logic [2:0] {
    COND_NEVER     = 3'd0,
    COND_ALWAYS    = 3'd1,
    COND_SCROLL    = 3'd2,
    COND_MORE_COPY = 3'd3,
    COND_MORE_FILL = 3'd4
  } cond_t;

  typedef logic [3:0] step_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_PUT    = 4'd1;
  localparam step_t STEP_DIV    = 4'd2;
  localparam step_t STEP_SETPOS = 4'd3;
  localparam step_t STEP_READ   = 4'd4;
  localparam step_t STEP_CLEAR  = 4'd5;
  localparam step_t STEP_SCR_RD = 4'd6;
  localparam step_t STEP_SCR_MV = 4'd7;
  localparam step_t STEP_FILL   = 4'd8;
  localparam step_t STEP_LAST   = STEP_FILL;

  // One microcode word: action, branch condition, branch target, finish flag.
  // Finish applies when the branch is not taken.
  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t target;
    logic  done;
  } uword_t;

  typedef struct packed {
    logic accept;
    act_t act;
  } dp_ctrl_t;

  typedef struct packed {
    logic need_scroll;
    logic more_copy;
    logic more_fill;
  } stat_t;

  // Control store
  function automatic uword_t ucode_rom(step_t step);
    uword_t w;
    w = '{act: ACT_NOP, cond: COND_NEVER, target: STEP_IDLE, done: 1'b0};
    case (step)
      STEP_PUT:    w = '{act: ACT_PUT,     cond: COND_SCROLL,    target: STEP_SCR_RD, done: 1'b1};
      STEP_DIV:    w = '{act: ACT_DIV,     cond: COND_NEVER,     target: STEP_IDLE,   done: 1'b0};
      STEP_SETPOS: w = '{act: ACT_SETPOS,  cond: COND_NEVER,     target: STEP_IDLE,   done: 1'b1};
      STEP_READ:   w = '{act: ACT_READ,    cond: COND_NEVER,     target: STEP_IDLE,   done: 1'b1};
      STEP_CLEAR:  w = '{act: ACT_CNT_CLR, cond: COND_ALWAYS,    target: STEP_FILL,   done: 1'b0};
      STEP_SCR_RD: w = '{act: ACT_SCR_RD,  cond: COND_NEVER,     target: STEP_IDLE,   done: 1'b0};
      STEP_SCR_MV: w = '{act: ACT_SCR_MV,  cond: COND_MORE_COPY, target: STEP_SCR_MV, done: 1'b0};
      STEP_FILL:   w = '{act: ACT_FILL,    cond: COND_MORE_FILL, target: STEP_FILL,   done: 1'b1};
      default:     w = '{act: ACT_NOP,     cond: COND_NEVER,     target: STEP_IDLE,   done: 1'b0};
    endcase
    return w;
  endfunction

  // Entry step for each command
  function automatic step_t dispatch(op_t op);
    step_t s;
    case (op)
      OP_PUT:    s = STEP_PUT;
      OP_SETPOS: s = STEP_DIV;
      OP_CLEAR:  s = STEP_CLEAR;
      OP_READ:   s = STEP_READ;
      default:   s = STEP_PUT;
    endcase
    return s;
  endfunction

endpackage

### rtl/tcw_seq.sv
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on tcw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_seq
  import tcw_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  op_t      opcode,
  input  stat_t    status,
  output logic     busy,
  output dp_ctrl_t ctrl,
  output logic     done_r
);

  step_t  step_r, step_nxt;
  uword_t word;
  logic   take;
  logic   finish;

  assign word = ucode_rom(step_r);
  assign busy = (step_r != STEP_IDLE);

  // Evaluate the branch condition of the current word
  always_comb begin
    case (word.cond)
      COND_NEVER:     take = 1'b0;
      COND_ALWAYS:    take = 1'b1;
      COND_SCROLL:    take = status.need_scroll;
      COND_MORE_COPY: take = status.more_copy;
      COND_MORE_FILL: take = status.more_fill;
      default:        take = 1'b0;
    endcase
  end

  // Pick the next step: dispatch, branch, finish or advance
  always_comb begin
    finish = 1'b0;
    if (!busy) begin
      step_nxt = start ? dispatch(opcode) : STEP_IDLE;
    end else if (take) begin
      step_nxt = word.target;
    end else if (word.done) begin
      step_nxt = STEP_IDLE;
      finish   = 1'b1;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  assign ctrl.accept = start && !busy;
  assign ctrl.act    = busy ? word.act : ACT_NOP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_IDLE;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= finish;
    end
  end

  `TCW_ASSERT(a_step_range, step_r <= STEP_LAST)
  `TCW_ASSERT_NEXT(a_accept_busy, start && !busy, step_r != STEP_IDLE)
  `TCW_ASSERT(a_done_after_work, done_r |-> $past(busy))

endmodule

### rtl/tcw_datapath.sv
// Datapath: cursor, attribute register, sweep counter and screen memory.
// Depends on tcw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_datapath
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  dp_ctrl_t           ctrl,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic [7:0]         char_code,
  input  logic [9:0]         pos_col,
  input  logic [7:0]         pos_row,
  input  logic [ADDR_W-1:0]  cell_index,
  output stat_t              status,
  output logic [COL_W-1:0]   cursor_col,
  output logic [ROW_W-1:0]   cursor_row,
  output logic [ADDR_W-1:0]  cursor_index,
  output logic [7:0]         read_char,
  output logic [7:0]         read_attr
);

  logic [15:0]       mem [CELLS];
  logic [15:0]       mem_q_r;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [15:0]       mem_wdata;

  logic [7:0]        attr_r;
  logic [COL_W-1:0]  cur_col_r, cur_col_nxt;
  logic [ROW_W-1:0]  cur_row_r, cur_row_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic [QUO_W-1:0]  quo_r;
  logic              rd_sel_r;
  logic [7:0]        char_r;
  logic [9:0]        pcol_r;
  logic [7:0]        prow_r;
  logic [ADDR_W-1:0] cidx_r;

  logic              is_nl, at_last_col, at_last_row, read_ok;
  logic [ADDR_W-1:0] cur_idx;
  logic [23:0]       div_prod;
  logic [ADDR_W-1:0] quo_cols, rem0, rem;
  logic              rem_fix;
  logic [QUO_W:0]    quo;
  logic [8:0]        row_sum;

  // Decode cursor conditions
  assign is_nl       = char_r inside {NEWLINE_CHAR, RETURN_CHAR};
  assign at_last_col = (cur_col_r == COL_W'(COLS - 1));
  assign at_last_row = (cur_row_r == ROW_W'(ROWS - 1));
  assign cur_idx     = ADDR_W'(cur_row_r) * ADDR_W'(COLS) + ADDR_W'(cur_col_r);
  assign read_ok     = (cidx_r < ADDR_W'(CELLS));

  assign status.need_scroll = (is_nl || at_last_col) && at_last_row;
  assign status.more_copy   = (cnt_r != ADDR_W'(LAST_COPY));
  assign status.more_fill   = (cnt_r != ADDR_W'(CELLS - 1));

  // Quotient estimate by reciprocal, then one correction step
  assign div_prod = 24'(pcol_r) * 24'(DIV_RECIP);
  assign quo_cols = ADDR_W'(quo_r) * ADDR_W'(COLS);
  assign rem0     = ADDR_W'(pcol_r) - quo_cols;
  assign rem_fix  = (rem0 >= ADDR_W'(COLS));
  assign rem      = rem_fix ? rem0 - ADDR_W'(COLS) : rem0;
  assign quo      = {1'b0, quo_r} + (QUO_W + 1)'(rem_fix);
  assign row_sum  = 9'(prow_r) + 9'(quo);

  // Memory ports per action
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cnt_r;
    mem_wdata = {attr_r, BLANK_CHAR};
    mem_re    = 1'b0;
    mem_raddr = ADDR_W'(cnt_r + ADDR_W'(COLS));
    case (ctrl.act)
      ACT_PUT: begin
        mem_we    = !is_nl;
        mem_waddr = cur_idx;
        mem_wdata = {attr_r, char_r};
      end
      ACT_READ: begin
        mem_re    = read_ok;
        mem_raddr = cidx_r;
      end
      ACT_SCR_RD: begin
        mem_re    = 1'b1;
      end
      ACT_SCR_MV: begin
        mem_we    = 1'b1;
        mem_wdata = mem_q_r;
        mem_re    = status.more_copy;
        mem_raddr = ADDR_W'(cnt_r + ADDR_W'(COLS + 1));
      end
      ACT_FILL: begin
        mem_we    = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Cursor and sweep counter updates
  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    cnt_nxt     = cnt_r;
    case (ctrl.act)
      ACT_PUT: begin
        cnt_nxt = '0;
        if (is_nl || at_last_col) begin
          cur_col_nxt = '0;
          if (!at_last_row) begin
            cur_row_nxt = cur_row_r + ROW_W'(1);
          end
        end else begin
          cur_col_nxt = cur_col_r + COL_W'(1);
        end
      end
      ACT_SETPOS: begin
        cur_col_nxt = rem[COL_W-1:0];
        cur_row_nxt = (row_sum >= 9'(ROWS)) ? ROW_W'(ROWS - 1) : row_sum[ROW_W-1:0];
      end
      ACT_CNT_CLR: begin
        cnt_nxt = '0;
      end
      ACT_SCR_MV, ACT_FILL: begin
        cnt_nxt = cnt_r + ADDR_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Screen memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // Capture command fields on accept; hold quotient and counter
  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      char_r <= char_code;
      pcol_r <= pos_col;
      prow_r <= pos_row;
      cidx_r <= cell_index;
    end
    if (ctrl.act == ACT_DIV) begin
      quo_r <= div_prod[RECIP_SH +: QUO_W];
    end
    cnt_r <= cnt_nxt;
  end

  // Control state: cursor, attribute, read select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
      attr_r    <= ATTR_RESET;
      rd_sel_r  <= 1'b0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
      if (cfg_wr_en) begin
        attr_r <= cfg_wr_data;
      end
      if (ctrl.act != ACT_NOP) begin
        rd_sel_r <= (ctrl.act == ACT_READ) && read_ok;
      end
    end
  end

  assign cursor_col   = cur_col_r;
  assign cursor_row   = cur_row_r;
  assign cursor_index = cur_idx;
  assign read_char    = rd_sel_r ? mem_q_r[7:0] : 8'd0;
  assign read_attr    = rd_sel_r ? mem_q_r[15:8] : 8'd0;

  `TCW_ASSERT(a_cursor_range,
              (cur_col_r < COL_W'(COLS)) && (cur_row_r < ROW_W'(ROWS)))
  `TCW_ASSERT_NEXT(a_fill_advance, (ctrl.act == ACT_FILL) && status.more_fill,
                   cnt_r == $past(cnt_r) + ADDR_W'(1))

endmodule

### rtl/text_console_writer.sv
// Top level of the text console writer: sequencer plus datapath.
// Depends on tcw_pkg, tcw_seq and tcw_datapath.
//
//   channel  direction  handshake           payload
//   in_      input      start / busy        opcode, char_code, pos_col, pos_row, cell_index
//   out_     output     out_strobe (1 cyc)  cursor_col, cursor_row, cursor_index,
//                                           read_char, read_attr
//   cfg_     input      cfg_wr_en           cfg_wr_data (attribute byte)
//
// Put character and read cell: PUT or READ step after accept, then back to idle.
// Set position: DIV step (reciprocal quotient), then SETPOS step (remainder fix).
// Clear screen: CLEAR then FILL; a put that scrolls: PUT, SCR_RD, SCR_MV, then FILL.
//   Both sweep the single-write-port screen memory one cell per cycle.
// Reset clears cursor and attribute (0x05); screen contents are undefined until written.
// The result is never stalled; busy holds off new commands while a sweep runs.
`timescale 1ns / 1ps

module text_console_writer
  import tcw_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [7:0]         in_char_code,
  input  logic [9:0]         in_pos_col,
  input  logic [7:0]         in_pos_row,
  input  logic [10:0]        in_cell_index,
  output logic               out_strobe,
  output logic [6:0]         out_cursor_col,
  output logic [4:0]         out_cursor_row,
  output logic [10:0]        out_cursor_index,
  output logic [7:0]         out_read_char,
  output logic [7:0]         out_read_attr,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data
);

  dp_ctrl_t ctrl;
  stat_t    status;

  tcw_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .opcode (op_t'(in_opcode)),
    .status (status),
    .busy   (busy),
    .ctrl   (ctrl),
    .done_r (out_strobe)
  );

  tcw_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .char_code    (in_char_code),
    .pos_col      (in_pos_col),
    .pos_row      (in_pos_row),
    .cell_index   (in_cell_index),
    .status       (status),
    .cursor_col   (out_cursor_col),
    .cursor_row   (out_cursor_row),
    .cursor_index (out_cursor_index),
    .read_char    (out_read_char),
    .read_attr    (out_read_attr)
  );

endmodule
